/* hdl/casu_pkg.sv */
// Shared types and constants for the collision-avoidance steering unit.
// No dependencies; used by casu_dsu and collision_avoidance_steering_unit.
package casu_pkg;

    // sequencer states of the top level
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,     // squared speed, squared distance, dot product
        ST_CHK,     // approach test, time saturation, start division
        ST_DIV,     // time of closest approach
        ST_SQD,     // distance root
        ST_SQS,     // speed root
        ST_TRAV,    // speed * time
        ST_SEP,     // separation and threat update
        ST_FIN,     // finish: pick vector form
        ST_FV,      // predicted relative position, one lane a cycle
        ST_NORM,    // magnitude pre-shift
        ST_SQ,      // sum of squares
        ST_LEN,     // start length root
        ST_LENW,
        ST_SCMUL,   // accel_limit * magnitude
        ST_SCDIV,   // start scaling division
        ST_SCW,
        ST_DONE     // hand result to output register
    } casu_state_t;

    // operations of the shared divide / square-root unit
    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } casu_op_t;

    typedef struct packed {
        logic     start;
        casu_op_t op;
    } casu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } casu_rsp_t;

    // configuration register indexes
    localparam logic [2:0] CFG_POS_X  = 3'd0;
    localparam logic [2:0] CFG_POS_Y  = 3'd1;
    localparam logic [2:0] CFG_POS_Z  = 3'd2;
    localparam logic [2:0] CFG_VEL_X  = 3'd3;
    localparam logic [2:0] CFG_VEL_Y  = 3'd4;
    localparam logic [2:0] CFG_VEL_Z  = 3'd5;
    localparam logic [2:0] CFG_RADIUS = 3'd6;
    localparam logic [2:0] CFG_ACCEL  = 3'd7;

    localparam logic KIND_NEIGHBOUR = 1'b0;
    localparam logic KIND_FINISH    = 1'b1;

    localparam logic [31:0] TIME_INF = 32'hFFFF_FFFF;
    localparam logic [32:0] SEP_MIN33 = 33'h1_0000_0000;          // -2^32
    localparam logic [49:0] SEP_MIN50 = 50'h3_FFFF_0000_0000;     // -2^32

endpackage

/* hdl/casu_dsu.sv */
// Shared iterative unit: restoring divider (32 quotient bits) and integer
// square root (32 root bits), one bit per cycle over one subtractor.
// Depends on casu_pkg.
module casu_dsu (
    input  logic               aclk,
    input  logic               aresetn,
    input  casu_pkg::casu_req_t req,
    input  logic [63:0]        num_hi,   // div: upper part (< den); sqrt: radicand
    input  logic [31:0]        num_lo,   // div: lower 32 bits of dividend
    input  logic [63:0]        den,
    output casu_pkg::casu_rsp_t rsp,
    output logic [31:0]        result
);

    casu_pkg::casu_op_t op_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        src_reg;
    logic [63:0]        den_reg;
    logic [31:0]        quo_reg;

    logic [65:0] sub_a;
    logic [65:0] sub_b;
    logic [65:0] diff;
    logic        ge;

    // shared trial subtraction
    always_comb begin
        if (op_reg == casu_pkg::OP_DIV) begin
            sub_a = {1'b0, rem_reg, src_reg[63]};
            sub_b = {2'b00, den_reg};
        end else begin
            sub_a = {31'd0, rem_reg[32:0], src_reg[63:62]};
            sub_b = {32'd0, quo_reg, 2'b01};
        end
        diff = sub_a - sub_b;
        ge   = ~diff[65];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                quo_reg  <= '0;
                den_reg  <= den;
                if (req.op == casu_pkg::OP_DIV) begin
                    rem_reg <= num_hi;
                    src_reg <= {num_lo, 32'd0};
                end else begin
                    rem_reg <= '0;
                    src_reg <= num_hi;
                end
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[63:0] : sub_a[63:0];
                quo_reg <= {quo_reg[30:0], ge};
                if (op_reg == casu_pkg::OP_DIV) begin
                    src_reg <= {src_reg[62:0], 1'b0};
                end else begin
                    src_reg <= {src_reg[61:0], 2'b00};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp    = '{busy: busy_reg, done: done_reg};
    assign result = quo_reg;

endmodule

/* hdl/collision_avoidance_steering_unit.sv */
// Top level of the collision-avoidance steering unit: sequencer, shared
// 33x33 multiplier and threat state. Depends on casu_pkg and casu_dsu.
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tuser kind, s_tdata neighbour
//  m_        out        m_tvalid / m_tready    m_tdata taken, steer x/y/z
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time; the bit-serial divide / square-root unit dominates the
// work of both neighbour and finish items. Reset is synchronous and active low
// and clears the search. s_tready is high only when idle; a result waits in the
// output register while the next item is taken. Configuration is always accepted.
module collision_avoidance_steering_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // kind
    // nb_pos_x, nb_pos_y, nb_pos_z, nb_vel_x, nb_vel_y, nb_vel_z, nb_radius
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // taken, steer_x, steer_y, steer_z
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    casu_pkg::casu_state_t state_reg;
    casu_pkg::casu_state_t state_next;

    // configuration
    logic [31:0] agent_pos_reg [3];
    logic [31:0] agent_vel_reg [3];
    logic [30:0] agent_radius_reg;
    logic [30:0] accel_limit_reg;

    // item work registers
    logic               kind_reg;
    logic signed [31:0] rp_reg [3];
    logic signed [31:0] rv_reg [3];
    logic [31:0]        rsum_reg;
    logic [63:0]        speed2_reg;
    logic [63:0]        dist2_reg;
    logic signed [65:0] dot_reg;
    logic [31:0]        t_reg;
    logic [31:0]        dist_reg;
    logic [31:0]        spd_reg;
    logic [3:0]         cnt_reg;
    logic [1:0]         lane_reg;
    logic [48:0]        mag_reg [3];
    logic               vpos_reg [3];
    logic [63:0]        sum2_reg;
    logic [31:0]        len_reg;
    logic               taken_res_reg;
    logic [31:0]        steer_res_reg [3];

    // threat state
    logic               found_reg;
    logic [31:0]        earliest_reg;
    logic signed [32:0] tsep_reg;
    logic [31:0]        tdist_reg;
    logic [31:0]        trsum_reg;
    logic signed [31:0] trp_reg [3];
    logic signed [31:0] trv_reg [3];

    // output register
    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_reg;

    // shared divide / root unit
    casu_pkg::casu_req_t dsu_req;
    casu_pkg::casu_rsp_t dsu_rsp;
    logic [63:0]         dsu_hi;
    logic [31:0]         dsu_lo;
    logic [63:0]         dsu_den;
    logic [31:0]         dsu_q;

    logic               accept;
    logic               out_free;
    logic [63:0]        neg_dot;
    logic               time_sat;
    logic               direct;
    logic               mag_over;
    logic signed [49:0] sep_full;
    logic               take;
    logic [1:0]         mul_lane;
    logic [1:0]         acc_lane;
    logic [3:0]         acc_idx;
    logic [46:0]        fv_p;
    logic signed [49:0] fv_v;
    logic [49:0]        fv_mag;
    logic [31:0]        rv_abs;

    // saturating 32-bit difference
    function automatic logic signed [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d[32] != d[31]) begin
            sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_sub = d[31:0];
        end
    endfunction

    // lane within a group of three
    function automatic logic [1:0] lane_of(input logic [3:0] c);
        case (c)
            4'd0, 4'd3, 4'd6: lane_of = 2'd0;
            4'd1, 4'd4, 4'd7: lane_of = 2'd1;
            4'd2, 4'd5, 4'd8: lane_of = 2'd2;
            default:          lane_of = 2'd0;
        endcase
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == casu_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign neg_dot  = 64'd0 - dot_reg[63:0];
    assign time_sat = (neg_dot[63:16] >= speed2_reg);
    assign direct   = (tsep_reg <= 33'sd0) || (tdist_reg < trsum_reg);
    assign mag_over = (mag_reg[0][48:31] != '0) || (mag_reg[1][48:31] != '0)
                   || (mag_reg[2][48:31] != '0);
    assign sep_full = $signed({18'd0, dist_reg}) - $signed({2'b00, prod_reg[63:16]});
    assign take     = !(sep_full > $signed({18'd0, rsum_reg}));
    assign mul_lane = lane_of(cnt_reg);
    assign acc_idx  = cnt_reg - 4'd1;
    assign acc_lane = lane_of(acc_idx);
    assign rv_abs   = trv_reg[mul_lane][31] ? (32'd0 - trv_reg[mul_lane]) : trv_reg[mul_lane];

    // predicted relative position for the lane whose product is ready
    always_comb begin
        fv_p = prod_reg[62:16];
        if (trv_reg[acc_lane][31]) begin
            fv_v = $signed({{18{trp_reg[acc_lane][31]}}, trp_reg[acc_lane]})
                 - $signed({3'b000, fv_p});
        end else begin
            fv_v = $signed({{18{trp_reg[acc_lane][31]}}, trp_reg[acc_lane]})
                 + $signed({3'b000, fv_p});
        end
        fv_mag = fv_v[49] ? (50'd0 - fv_v) : fv_v;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            casu_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == casu_pkg::KIND_FINISH) ? casu_pkg::ST_FIN
                                                                     : casu_pkg::ST_MUL;
                end
            end
            casu_pkg::ST_MUL: begin
                if (cnt_reg == 4'd9) state_next = casu_pkg::ST_CHK;
            end
            casu_pkg::ST_CHK: begin
                if (speed2_reg == 64'd0 || !dot_reg[65] || time_sat) begin
                    state_next = casu_pkg::ST_DONE;
                end else begin
                    state_next = casu_pkg::ST_DIV;
                end
            end
            casu_pkg::ST_DIV: begin
                if (dsu_rsp.done) begin
                    if (dsu_q == 32'd0 || dsu_q >= earliest_reg) begin
                        state_next = casu_pkg::ST_DONE;
                    end else begin
                        state_next = casu_pkg::ST_SQD;
                    end
                end
            end
            casu_pkg::ST_SQD: begin
                if (dsu_rsp.done) state_next = casu_pkg::ST_SQS;
            end
            casu_pkg::ST_SQS: begin
                if (dsu_rsp.done) state_next = casu_pkg::ST_TRAV;
            end
            casu_pkg::ST_TRAV: state_next = casu_pkg::ST_SEP;
            casu_pkg::ST_SEP:  state_next = casu_pkg::ST_DONE;
            casu_pkg::ST_FIN: begin
                if (!found_reg)  state_next = casu_pkg::ST_DONE;
                else if (direct) state_next = casu_pkg::ST_NORM;
                else             state_next = casu_pkg::ST_FV;
            end
            casu_pkg::ST_FV: begin
                if (cnt_reg == 4'd3) state_next = casu_pkg::ST_NORM;
            end
            casu_pkg::ST_NORM: begin
                if (!mag_over) state_next = casu_pkg::ST_SQ;
            end
            casu_pkg::ST_SQ: begin
                if (cnt_reg == 4'd3) state_next = casu_pkg::ST_LEN;
            end
            casu_pkg::ST_LEN: state_next = casu_pkg::ST_LENW;
            casu_pkg::ST_LENW: begin
                if (dsu_rsp.done) begin
                    state_next = (dsu_q == 32'd0) ? casu_pkg::ST_DONE : casu_pkg::ST_SCMUL;
                end
            end
            casu_pkg::ST_SCMUL: state_next = casu_pkg::ST_SCDIV;
            casu_pkg::ST_SCDIV: state_next = casu_pkg::ST_SCW;
            casu_pkg::ST_SCW: begin
                if (dsu_rsp.done) begin
                    state_next = (lane_reg == 2'd2) ? casu_pkg::ST_DONE : casu_pkg::ST_SCMUL;
                end
            end
            casu_pkg::ST_DONE: begin
                if (out_free) state_next = casu_pkg::ST_IDLE;
            end
            default: state_next = casu_pkg::ST_IDLE;
        endcase
    end

    // unit requests and multiplier operands
    always_comb begin
        dsu_req = '{start: 1'b0, op: casu_pkg::OP_DIV};
        dsu_hi  = '0;
        dsu_lo  = '0;
        dsu_den = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            casu_pkg::ST_MUL: begin
                if (cnt_reg < 4'd3) begin
                    mul_a = {rv_reg[mul_lane][31], rv_reg[mul_lane]};
                    mul_b = {rv_reg[mul_lane][31], rv_reg[mul_lane]};
                end else if (cnt_reg < 4'd6) begin
                    mul_a = {rp_reg[mul_lane][31], rp_reg[mul_lane]};
                    mul_b = {rp_reg[mul_lane][31], rp_reg[mul_lane]};
                end else begin
                    mul_a = {rp_reg[mul_lane][31], rp_reg[mul_lane]};
                    mul_b = {rv_reg[mul_lane][31], rv_reg[mul_lane]};
                end
            end
            casu_pkg::ST_CHK: begin
                dsu_req.start = (speed2_reg != 64'd0) && dot_reg[65] && !time_sat;
                dsu_req.op    = casu_pkg::OP_DIV;
                dsu_hi        = {16'd0, neg_dot[63:16]};
                dsu_lo        = {neg_dot[15:0], 16'd0};
                dsu_den       = speed2_reg;
            end
            casu_pkg::ST_DIV: begin
                dsu_req.start = dsu_rsp.done && (dsu_q != 32'd0) && (dsu_q < earliest_reg);
                dsu_req.op    = casu_pkg::OP_SQRT;
                dsu_hi        = dist2_reg;
            end
            casu_pkg::ST_SQD: begin
                dsu_req.start = dsu_rsp.done;
                dsu_req.op    = casu_pkg::OP_SQRT;
                dsu_hi        = speed2_reg;
            end
            casu_pkg::ST_TRAV: begin
                mul_a = {1'b0, spd_reg};
                mul_b = {1'b0, t_reg};
            end
            casu_pkg::ST_FV: begin
                mul_a = {1'b0, rv_abs};
                mul_b = {1'b0, earliest_reg};
            end
            casu_pkg::ST_SQ: begin
                mul_a = {2'b00, mag_reg[mul_lane][30:0]};
                mul_b = {2'b00, mag_reg[mul_lane][30:0]};
            end
            casu_pkg::ST_LEN: begin
                dsu_req.start = 1'b1;
                dsu_req.op    = casu_pkg::OP_SQRT;
                dsu_hi        = sum2_reg;
            end
            casu_pkg::ST_SCMUL: begin
                mul_a = {2'b00, accel_limit_reg};
                mul_b = {2'b00, mag_reg[lane_reg][30:0]};
            end
            casu_pkg::ST_SCDIV: begin
                dsu_req.start = 1'b1;
                dsu_req.op    = casu_pkg::OP_DIV;
                dsu_hi        = {32'd0, prod_reg[63:32]};
                dsu_lo        = prod_reg[31:0];
                dsu_den       = {32'd0, len_reg};
            end
            default: begin
                dsu_req = '{start: 1'b0, op: casu_pkg::OP_DIV};
            end
        endcase
    end

    casu_dsu u_dsu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dsu_req),
        .num_hi  (dsu_hi),
        .num_lo  (dsu_lo),
        .den     (dsu_den),
        .rsp     (dsu_rsp),
        .result  (dsu_q)
    );

    // multiplier output register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // state, configuration, threat state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= casu_pkg::ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            agent_radius_reg <= '0;
            accel_limit_reg  <= '0;
            found_reg        <= 1'b0;
            earliest_reg     <= casu_pkg::TIME_INF;
            tsep_reg         <= '0;
            tdist_reg        <= '0;
            trsum_reg        <= '0;
            for (int i = 0; i < 3; i++) begin
                agent_pos_reg[i] <= '0;
                agent_vel_reg[i] <= '0;
                trp_reg[i]       <= '0;
                trv_reg[i]       <= '0;
            end
        end else begin
            state_reg <= state_next;

            // configuration transfer
            if (cfg_valid) begin
                case (cfg_index)
                    casu_pkg::CFG_POS_X:  agent_pos_reg[0] <= cfg_data;
                    casu_pkg::CFG_POS_Y:  agent_pos_reg[1] <= cfg_data;
                    casu_pkg::CFG_POS_Z:  agent_pos_reg[2] <= cfg_data;
                    casu_pkg::CFG_VEL_X:  agent_vel_reg[0] <= cfg_data;
                    casu_pkg::CFG_VEL_Y:  agent_vel_reg[1] <= cfg_data;
                    casu_pkg::CFG_VEL_Z:  agent_vel_reg[2] <= cfg_data;
                    casu_pkg::CFG_RADIUS: agent_radius_reg <= cfg_data[30:0];
                    casu_pkg::CFG_ACCEL:  accel_limit_reg  <= cfg_data[30:0];
                    default:              agent_radius_reg <= agent_radius_reg;
                endcase
            end

            // new first threat
            if (state_reg == casu_pkg::ST_SEP && take) begin
                found_reg    <= 1'b1;
                earliest_reg <= t_reg;
                tsep_reg     <= (sep_full < $signed(casu_pkg::SEP_MIN50))
                              ? $signed(casu_pkg::SEP_MIN33) : sep_full[32:0];
                tdist_reg    <= dist_reg;
                trsum_reg    <= rsum_reg;
                for (int i = 0; i < 3; i++) begin
                    trp_reg[i] <= rp_reg[i];
                    trv_reg[i] <= rv_reg[i];
                end
            end

            // output transfer and search clear on finish
            if (state_reg == casu_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (kind_reg == casu_pkg::KIND_FINISH) begin
                    found_reg    <= 1'b0;
                    earliest_reg <= casu_pkg::TIME_INF;
                    tsep_reg     <= '0;
                    tdist_reg    <= '0;
                    trsum_reg    <= '0;
                    for (int i = 0; i < 3; i++) begin
                        trp_reg[i] <= '0;
                        trv_reg[i] <= '0;
                    end
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (state_reg == casu_pkg::ST_DONE && out_free) begin
            m_tdata_reg <= {7'd0, steer_res_reg[2], steer_res_reg[1], steer_res_reg[0],
                            taken_res_reg};
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            casu_pkg::ST_IDLE: begin
                if (accept) begin
                    kind_reg      <= s_tuser;
                    rp_reg[0]     <= sat_sub(s_tdata[31:0],    agent_pos_reg[0]);
                    rp_reg[1]     <= sat_sub(s_tdata[63:32],   agent_pos_reg[1]);
                    rp_reg[2]     <= sat_sub(s_tdata[95:64],   agent_pos_reg[2]);
                    rv_reg[0]     <= sat_sub(s_tdata[127:96],  agent_vel_reg[0]);
                    rv_reg[1]     <= sat_sub(s_tdata[159:128], agent_vel_reg[1]);
                    rv_reg[2]     <= sat_sub(s_tdata[191:160], agent_vel_reg[2]);
                    rsum_reg      <= {1'b0, agent_radius_reg} + {1'b0, s_tdata[222:192]};
                    speed2_reg    <= '0;
                    dist2_reg     <= '0;
                    dot_reg       <= '0;
                    sum2_reg      <= '0;
                    cnt_reg       <= '0;
                    lane_reg      <= '0;
                    taken_res_reg <= 1'b0;
                    for (int i = 0; i < 3; i++) steer_res_reg[i] <= '0;
                end
            end
            casu_pkg::ST_MUL: begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg != 4'd0) begin
                    if (acc_idx < 4'd3)      speed2_reg <= speed2_reg + prod_reg[63:0];
                    else if (acc_idx < 4'd6) dist2_reg  <= dist2_reg + prod_reg[63:0];
                    else                     dot_reg    <= dot_reg + prod_reg;
                end
            end
            casu_pkg::ST_DIV: begin
                if (dsu_rsp.done) t_reg <= dsu_q;
            end
            casu_pkg::ST_SQD: begin
                if (dsu_rsp.done) dist_reg <= dsu_q;
            end
            casu_pkg::ST_SQS: begin
                if (dsu_rsp.done) spd_reg <= dsu_q;
            end
            casu_pkg::ST_SEP: begin
                taken_res_reg <= take;
            end
            casu_pkg::ST_FIN: begin
                cnt_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i]  <= {17'd0, (trp_reg[i][31] ? (32'd0 - trp_reg[i]) : trp_reg[i])};
                    vpos_reg[i] <= (trp_reg[i] > 32'sd0);
                end
            end
            casu_pkg::ST_FV: begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg != 4'd0) begin
                    mag_reg[acc_lane]  <= fv_mag[48:0];
                    vpos_reg[acc_lane] <= (fv_v > 50'sd0);
                end
            end
            casu_pkg::ST_NORM: begin
                cnt_reg <= '0;
                if (mag_over) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
            end
            casu_pkg::ST_SQ: begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg != 4'd0) sum2_reg <= sum2_reg + prod_reg[63:0];
            end
            casu_pkg::ST_LENW: begin
                if (dsu_rsp.done) len_reg <= dsu_q;
            end
            casu_pkg::ST_SCW: begin
                if (dsu_rsp.done) begin
                    steer_res_reg[lane_reg] <= vpos_reg[lane_reg] ? (32'd0 - dsu_q) : dsu_q;
                    lane_reg <= lane_reg + 2'd1;
                end
            end
            default: begin
                kind_reg <= kind_reg;
            end
        endcase
    end

endmodule

/* sim/testbench.sv */
// Testbench for the collision-avoidance steering unit: a directed table, then
// random neighbour/finish runs, each result checked against a local predictor.
// Depends on casu_pkg and collision_avoidance_steering_unit.
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1600;

    typedef struct packed {
        logic        taken;
        logic [31:0] sx, sy, sz;
    } steer_res_t;

    typedef struct {
        logic              kind;
        logic signed [31:0] p[3];
        logic signed [31:0] v[3];
        logic [30:0]       rad;
        logic              has_exp;
        steer_res_t        exp;
    } nb_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
    logic [223:0] s_tdata = '0;
    logic m_tvalid, m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #4 aclk = ~aclk;

    collision_avoidance_steering_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of registers and threat state
    logic signed [63:0] ag_pos[3], ag_vel[3];
    logic [63:0]        ag_radius, ag_accel;
    logic               thr_found;
    logic [31:0]        thr_time;
    logic signed [63:0] thr_sep;
    logic [63:0]        thr_dist, thr_rsum;
    logic signed [63:0] thr_rp[3], thr_rv[3];

    steer_res_t expected_q[$];
    int  n_fail = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  no_idle = 0;

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic clear_threat();
        thr_found = 0;
        thr_time = casu_pkg::TIME_INF;
        thr_sep = 0;
        thr_dist = 0;
        thr_rsum = 0;
        for (int i = 0; i < 3; i++) begin
            thr_rp[i] = 0;
            thr_rv[i] = 0;
        end
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx < casu_pkg::CFG_VEL_X) ag_pos[idx] = {{32{val[31]}}, val};
        else if (idx < casu_pkg::CFG_RADIUS)
            ag_vel[idx - casu_pkg::CFG_VEL_X] = {{32{val[31]}}, val};
        else if (idx == casu_pkg::CFG_RADIUS) ag_radius = {33'd0, val[30:0]};
        else ag_accel = {33'd0, val[30:0]};
        @(posedge aclk);
    endtask

    // steering for a finish transfer
    function automatic steer_res_t predict_finish();
        steer_res_t r;
        logic signed [63:0] w[3];
        logic [63:0] mag[3], m, sum, len, q, pr;
        logic direct;
        int s;
        r = '0;
        if (!thr_found) return r;
        direct = (thr_sep <= 0) || (thr_dist < thr_rsum);
        for (int i = 0; i < 3; i++) begin
            if (direct) begin
                w[i] = thr_rp[i];
            end else begin
                m = thr_rv[i] < 0 ? -thr_rv[i] : thr_rv[i];
                pr = (m * {32'd0, thr_time}) >> 16;
                w[i] = thr_rp[i] + (thr_rv[i] < 0 ? -$signed(pr) : $signed(pr));
            end
        end
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = w[i] < 0 ? -w[i] : w[i];
            if (mag[i] > m) m = mag[i];
        end
        s = 0;
        while ((m >> s) >= 64'h8000_0000) s++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= s;
            sum += mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (len != 0) q = (ag_accel * mag[i]) / len;
            if (w[i] > 0) q = -q;
            if (i == 0) r.sx = q[31:0];
            else if (i == 1) r.sy = q[31:0];
            else r.sz = q[31:0];
        end
        return r;
    endfunction

    // first-threat test for a neighbour transfer
    function automatic steer_res_t predict_neighbour(nb_item_t it);
        steer_res_t r;
        logic signed [63:0] rp[3], rv[3], prod, sep;
        logic [63:0] spd2, dst2, pos, neg, dist_v, spd, trav, rsum, q;
        logic [31:0] t;
        r = '0;
        spd2 = 0; dst2 = 0; pos = 0; neg = 0;
        for (int i = 0; i < 3; i++) begin
            rp[i] = clamp32(64'(it.p[i]) - ag_pos[i]);
            rv[i] = clamp32(64'(it.v[i]) - ag_vel[i]);
            spd2 += rv[i] * rv[i];
            dst2 += rp[i] * rp[i];
            prod = rp[i] * rv[i];
            if (prod >= 0) pos += prod;
            else neg += -prod;
        end
        if (spd2 == 0 || neg <= pos) return r;
        begin
            logic [79:0] num;
            logic [79:0] qq;
            num = {16'd0, neg - pos} << 16;
            qq = num / {16'd0, spd2};
            t = (qq > 80'hFFFF_FFFF) ? casu_pkg::TIME_INF : qq[31:0];
        end
        if (t == 0 || t >= thr_time) return r;
        dist_v = root64(dst2);
        spd = root64(spd2);
        trav = (spd * {32'd0, t}) >> 16;
        sep = $signed(dist_v) - $signed(trav);
        if (sep < -64'sd4294967296) sep = -64'sd4294967296;
        rsum = ag_radius + {33'd0, it.rad};
        if (sep > $signed(rsum)) return r;
        thr_found = 1;
        thr_time = t;
        thr_sep = sep;
        thr_dist = dist_v;
        thr_rsum = rsum;
        for (int i = 0; i < 3; i++) begin
            thr_rp[i] = rp[i];
            thr_rv[i] = rv[i];
        end
        r.taken = 1'b1;
        return r;
    endfunction

    task automatic send_item(nb_item_t it);
        steer_res_t e;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {1'b0, it.rad, it.v[2], it.v[1], it.v[0], it.p[2], it.p[1], it.p[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (it.kind == casu_pkg::KIND_FINISH) begin
            e = predict_finish();
            clear_threat();
        end else begin
            e = predict_neighbour(it);
        end
        if (it.has_exp && e != it.exp) begin
            $error("table row: predictor %h disagrees with typed %h", e, it.exp);
            n_fail++;
        end
        expected_q.push_back(it.has_exp ? it.exp : e);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver with random stall bursts
    always @(posedge aclk) begin
        if (!aresetn || no_idle) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        steer_res_t got, e;
        if (aresetn && m_tvalid && m_tready) begin
            got.taken = m_tdata[0];
            got.sx    = m_tdata[32:1];
            got.sy    = m_tdata[64:33];
            got.sz    = m_tdata[96:65];
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                n_fail++;
            end else begin
                e = expected_q.pop_front();
                if (got.taken !== e.taken) begin
                    $error("taken: expected %0d, got %0d", e.taken, got.taken);
                    n_fail++;
                end
                if (got.sx !== e.sx) begin
                    $error("steer_x: expected %h, got %h", e.sx, got.sx);
                    n_fail++;
                end
                if (got.sy !== e.sy) begin
                    $error("steer_y: expected %h, got %h", e.sy, got.sy);
                    n_fail++;
                end
                if (got.sz !== e.sz) begin
                    $error("steer_z: expected %h, got %h", e.sz, got.sz);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_val(int scale);
        logic [31:0] v;
        v = $urandom;
        case (scale)
            0: v = {{14{v[17]}}, v[17:0]};
            1: v = {{8{v[23]}}, v[23:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic nb_item_t make_nb(logic kind, int scale);
        nb_item_t it;
        it.kind = kind;
        for (int i = 0; i < 3; i++) begin
            it.p[i] = rand_val(scale);
            it.v[i] = rand_val(scale);
        end
        it.rad = (scale == 2) ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
        it.has_exp = 0;
        it.exp = '0;
        return it;
    endfunction

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_config(bit extreme);
        for (int i = 0; i < 6; i++)
            write_register(3'(i), extreme ? ($urandom_range(0, 1) ? 32'h8000_0000
                                                                   : 32'h7FFF_FFFF)
                                          : rand_val(0));
        write_register(casu_pkg::CFG_RADIUS,
                       extreme ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0002_0000));
        write_register(casu_pkg::CFG_ACCEL, extreme ? 32'h7FFF_FFFF : $urandom);
    endtask

    nb_item_t directed[$];

    task automatic add_row(logic kind, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                           logic [30:0] rad, logic he, steer_res_t e);
        nb_item_t it;
        it.kind = kind;
        it.p[0] = px; it.p[1] = py; it.p[2] = pz;
        it.v[0] = vx; it.v[1] = vy; it.v[2] = vz;
        it.rad = rad;
        it.has_exp = he;
        it.exp = e;
        directed.push_back(it);
    endtask

    initial begin
        nb_item_t it;
        int phase;
        for (int i = 0; i < 3; i++) begin
            ag_pos[i] = 0;
            ag_vel[i] = 0;
        end
        ag_radius = 0;
        ag_accel = 0;
        clear_threat();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset registers
        add_row(casu_pkg::KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 1, '0);       // empty search
        add_row(casu_pkg::KIND_NEIGHBOUR, 0, 0, 0, 0, 0, 0, 0, 1, '0);    // zero speed
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0,
                1, '0);                                                   // receding
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h000A_0000, 0, 0, 32'hFFFF_0000, 0, 0,
                31'h0001_0000, 1, '{1'b1, 32'd0, 32'd0, 32'd0});          // head-on threat
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h000A_0000, 0, 0, 32'hFFFF_0000, 0, 0,
                31'h0001_0000, 1, '0);                                    // same time
        add_row(casu_pkg::KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 1, '0);       // accel 0
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
                32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 0, '0);
        add_row(casu_pkg::KIND_NEIGHBOUR, 1, 0, 0, 32'h8000_0000, 0, 0, 0,
                0, '0);                                                   // time floors to 0
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h8000_0000, 0, 0, 1, 0, 0, 0,
                0, '0);                                                   // saturated time
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h0010_0000, 32'h0000_8000, 0, 32'hFFFF_0000,
                0, 0, 0, 0, '0);                                          // miss
        add_row(casu_pkg::KIND_NEIGHBOUR, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000,
                32'hFFFE_0000, 32'hFFFF_8000, 0, 31'h0004_0000, 0, '0);
        add_row(casu_pkg::KIND_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, '0);
        foreach (directed[i]) begin
            if (i == 6) begin
                drain();
                write_register(casu_pkg::CFG_ACCEL, 32'h7FFF_FFFF);
                write_register(casu_pkg::CFG_RADIUS, 32'h0000_8000);
            end
            send_item(directed[i]);
        end
        drain();

        // random runs: mostly small values so threats and finishes occur
        for (int n = 0; n < N_RANDOM; ) begin
            phase = n / 200;
            if (n % 200 == 0) begin
                drain();
                random_config(phase == 3 || phase == 7);
                if (phase == 5) for (int i = 0; i < 8; i++) write_register(3'(i), 32'd0);
                if (n >= N_RANDOM - 200) no_idle = 1;
            end
            it = make_nb(casu_pkg::KIND_NEIGHBOUR,
                         ($urandom_range(0, 9) == 0) ? 2 : ($urandom_range(0, 2) == 0));
            if ($urandom_range(0, 5) == 0) it.kind = casu_pkg::KIND_FINISH;
            send_item(it);
            n++;
        end
        it = make_nb(casu_pkg::KIND_FINISH, 0);
        send_item(it);
        drain();

        if (n_fail == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
